// ----- sv/l2sr_pkg.sv -----
// Shared constants, widths and helper functions for the 2D lattice shift reduction block.
// No dependencies; compile first.
`default_nettype none

package l2sr_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int MAX_PASSES  = 256;

    localparam int WORK_W  = COORD_WIDTH + 2;
    localparam int OUT_W   = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * WORK_W;
    localparam int NORM_W  = PROD_W;
    localparam int IP_W    = PROD_W + 1;
    localparam int CMP_W   = IP_W + 1;
    localparam int PASS_W  = $clog2(MAX_PASSES + 1);
    localparam int MSTEP_W = 3;

    typedef logic signed [WORK_W-1:0] work_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic        [NORM_W-1:0] norm_t;
    typedef logic signed [IP_W-1:0]   ip_t;
    typedef logic        [CMP_W-1:0]  cmp_t;

    // True when bit length of p is at least that of x.
    function automatic logic msb_ge(input cmp_t p, input cmp_t x);
        return !((p < x) && (p < (p ^ x)));
    endfunction

endpackage

`default_nettype wire

// ----- sv/l2sr_ifs.sv -----
// Handshake channel interfaces for the basis input and the reduced result.
// Depends on l2sr_pkg for field widths.
`default_nettype none

interface l2sr_basis_if
    import l2sr_pkg::*;
    ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;

    modport source (output valid, first_x, first_y, second_x, second_y, input ready);
    modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface l2sr_reduced_if
    import l2sr_pkg::*;
    ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] short_x;
    logic signed [OUT_W-1:0] short_y;
    logic signed [OUT_W-1:0] long_x;
    logic signed [OUT_W-1:0] long_y;
    logic                    not_converged;

    modport source (output valid, short_x, short_y, long_x, long_y, not_converged,
                    input ready);
    modport sink   (input valid, short_x, short_y, long_x, long_y, not_converged,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/l2sr_mul.sv -----
// Shared signed multiplier with a registered product, one product per cycle.
// Depends on l2sr_pkg.
`default_nettype none

module l2sr_mul
    import l2sr_pkg::*;
(
    input  wire logic  clk,
    input  wire work_t op_a,
    input  wire work_t op_b,
    output prod_t      prod
);

    prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- sv/lattice_2d_shift_reduction.sv -----
// Top level of the 2D lattice shift reduction block: sequencer, working registers, output beat.
// Depends on l2sr_pkg, l2sr_ifs (channel interfaces) and l2sr_mul (shared multiplier).
`default_nettype none

// Reduces a 2D lattice basis (Lagrange reduction with power-of-two quotients) one basis
// at a time. A basis beat is taken only while the block is idle; one result beat follows,
// shorter vector first, with not_converged set if MAX_PASSES passes ran out. All norms and
// inner products run through one shared multiplier, one product per cycle. The initial
// norms and inner product come first; each pass then runs its multiplier steps, swap,
// test, bit-length compare steps that find the pass's power-of-two shift, and update;
// the final test and the output beat close the item. A result waiting in the output
// register does not block the next basis; only when the next result is finished while
// the previous one is still unclaimed does the block hold its last step and take no
// new basis.
module lattice_2d_shift_reduction
    import l2sr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    l2sr_basis_if.sink    basis,
    l2sr_reduced_if.source reduced
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_SWAP   = 3'd2;
    localparam logic [2:0] S_TEST   = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_UPDATE = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // Multiplier schedule: squares of a, then a.b, then squares of b.
    localparam logic [MSTEP_W-1:0] M_AX_AX   = 3'd0;
    localparam logic [MSTEP_W-1:0] M_AY_AY   = 3'd1;
    localparam logic [MSTEP_W-1:0] M_AX_BX   = 3'd2;
    localparam logic [MSTEP_W-1:0] M_AY_BY   = 3'd3;
    localparam logic [MSTEP_W-1:0] M_BX_BX   = 3'd4;
    localparam logic [MSTEP_W-1:0] M_BY_BY   = 3'd5;
    localparam logic [MSTEP_W-1:0] M_LAST_FULL = 3'd6;
    localparam logic [MSTEP_W-1:0] M_LAST_PASS = 3'd4;

    // Control state
    logic [2:0]         state_reg, state_next;
    logic [MSTEP_W-1:0] mstep_reg, mstep_next;
    logic               full_reg, full_next;
    logic [PASS_W-1:0]  pass_reg, pass_next;
    logic               capped_reg, capped_next;
    logic               rvalid_reg, rvalid_next;

    // Datapath state
    work_t ax_reg, ax_next, ay_reg, ay_next, bx_reg, bx_next, by_reg, by_next;
    work_t dbx_reg, dbx_next, dby_reg, dby_next;
    norm_t norm_a_reg, norm_a_next, norm_b_reg, norm_b_next;
    ip_t   ip_reg, ip_next;
    prod_t part_reg, part_next;
    cmp_t  pval_reg, pval_next, xcmp_reg, xcmp_next;

    logic signed [OUT_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [OUT_W-1:0] lx_reg, lx_next, ly_reg, ly_next;
    logic                    nc_reg, nc_next;

    work_t op_a, op_b;
    prod_t prod;
    ip_t   pair_sum;
    ip_t   p_ip;
    cmp_t  mag;
    logic  ip_neg;
    logic  stop_ok;
    logic  [MSTEP_W-1:0] mstep_prev;
    logic  [MSTEP_W-1:0] mstep_last;

    l2sr_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Pick operands for the current multiplier step.
    always_comb
    begin
        case (mstep_reg)
            M_AX_AX: begin op_a = ax_reg; op_b = ax_reg; end
            M_AY_AY: begin op_a = ay_reg; op_b = ay_reg; end
            M_AX_BX: begin op_a = ax_reg; op_b = bx_reg; end
            M_AY_BY: begin op_a = ay_reg; op_b = by_reg; end
            M_BX_BX: begin op_a = bx_reg; op_b = bx_reg; end
            M_BY_BY: begin op_a = by_reg; op_b = by_reg; end
            default: begin op_a = '0;     op_b = '0;     end
        endcase
    end

    assign mstep_prev = mstep_reg - MSTEP_W'(1);
    assign mstep_last = full_reg ? M_LAST_FULL : M_LAST_PASS;
    assign pair_sum   = IP_W'(part_reg) + IP_W'(prod);

    assign ip_neg  = ip_reg[IP_W-1];
    assign mag     = ip_neg ? (cmp_t'(0) - CMP_W'(ip_reg)) : CMP_W'(ip_reg);
    // Stop once twice |inner product| no longer exceeds the shorter norm.
    assign stop_ok = ({mag, 1'b0} <= {3'b000, norm_b_reg});
    // Bit-length source: the magnitude, less one for a negative inner product.
    assign p_ip    = ip_neg ? ~ip_reg : ip_reg;

    always_comb
    begin
        state_next  = state_reg;
        mstep_next  = mstep_reg;
        full_next   = full_reg;
        pass_next   = pass_reg;
        capped_next = capped_reg;
        rvalid_next = rvalid_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        dbx_next    = dbx_reg;
        dby_next    = dby_reg;
        norm_a_next = norm_a_reg;
        norm_b_next = norm_b_reg;
        ip_next     = ip_reg;
        part_next   = part_reg;
        pval_next   = pval_reg;
        xcmp_next   = xcmp_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        lx_next     = lx_reg;
        ly_next     = ly_reg;
        nc_next     = nc_reg;

        // Drop the result beat once the sink takes it.
        if (rvalid_reg && reduced.ready)
        begin
            rvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (basis.valid)
                begin
                    ax_next     = WORK_W'(basis.first_x);
                    ay_next     = WORK_W'(basis.first_y);
                    bx_next     = WORK_W'(basis.second_x);
                    by_next     = WORK_W'(basis.second_y);
                    pass_next   = '0;
                    capped_next = 1'b0;
                    full_next   = 1'b1;
                    mstep_next  = '0;
                    state_next  = S_MUL;
                end
            end

            S_MUL:
            begin
                // Product of the previous step sits in the multiplier register.
                if (mstep_reg != '0)
                begin
                    case (mstep_prev)
                        M_AX_AX, M_AX_BX, M_BX_BX: part_next = prod;
                        M_AY_AY: norm_a_next = NORM_W'(pair_sum);
                        M_AY_BY: ip_next     = pair_sum;
                        M_BY_BY: norm_b_next = NORM_W'(pair_sum);
                        default: part_next   = part_reg;
                    endcase
                end
                if (mstep_reg == mstep_last)
                begin
                    state_next = S_SWAP;
                end
                else
                begin
                    mstep_next = mstep_reg + MSTEP_W'(1);
                end
            end

            S_SWAP:
            begin
                // Keep the shorter vector in b; ties leave the order alone.
                if (norm_a_reg < norm_b_reg)
                begin
                    ax_next     = bx_reg;
                    ay_next     = by_reg;
                    bx_next     = ax_reg;
                    by_next     = ay_reg;
                    norm_a_next = norm_b_reg;
                    norm_b_next = norm_a_reg;
                end
                state_next = S_TEST;
            end

            S_TEST:
            begin
                if (stop_ok)
                begin
                    state_next = S_DONE;
                end
                else if (pass_reg >= PASS_W'(MAX_PASSES))
                begin
                    capped_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    pval_next  = {1'b0, p_ip};
                    xcmp_next  = {1'b0, norm_b_reg, 1'b0};
                    dbx_next   = bx_reg;
                    dby_next   = by_reg;
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // Advance the shift while the source is at least as long as norm_b << (s+1).
                if (msb_ge(pval_reg, xcmp_reg))
                begin
                    xcmp_next = {xcmp_reg[CMP_W-2:0], 1'b0};
                    dbx_next  = {dbx_reg[WORK_W-2:0], 1'b0};
                    dby_next  = {dby_reg[WORK_W-2:0], 1'b0};
                end
                else
                begin
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                if (!ip_neg && (ip_reg != '0))
                begin
                    ax_next = ax_reg - dbx_reg;
                    ay_next = ay_reg - dby_reg;
                end
                else
                begin
                    ax_next = ax_reg + dbx_reg;
                    ay_next = ay_reg + dby_reg;
                end
                pass_next  = pass_reg + PASS_W'(1);
                full_next  = 1'b0;
                mstep_next = '0;
                state_next = S_MUL;
            end

            S_DONE:
            begin
                // Hold until the output register is free.
                if (!rvalid_reg || reduced.ready)
                begin
                    sx_next     = OUT_W'(bx_reg);
                    sy_next     = OUT_W'(by_reg);
                    lx_next     = OUT_W'(ax_reg);
                    ly_next     = OUT_W'(ay_reg);
                    nc_next     = capped_reg;
                    rvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mstep_reg  <= '0;
            full_reg   <= 1'b0;
            pass_reg   <= '0;
            capped_reg <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mstep_reg  <= mstep_next;
            full_reg   <= full_next;
            pass_reg   <= pass_next;
            capped_reg <= capped_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        dbx_reg    <= dbx_next;
        dby_reg    <= dby_next;
        norm_a_reg <= norm_a_next;
        norm_b_reg <= norm_b_next;
        ip_reg     <= ip_next;
        part_reg   <= part_next;
        pval_reg   <= pval_next;
        xcmp_reg   <= xcmp_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        lx_reg     <= lx_next;
        ly_reg     <= ly_next;
        nc_reg     <= nc_next;
    end

    assign basis.ready           = (state_reg == S_IDLE);
    assign reduced.valid         = rvalid_reg;
    assign reduced.short_x       = sx_reg;
    assign reduced.short_y       = sy_reg;
    assign reduced.long_x        = lx_reg;
    assign reduced.long_y        = ly_reg;
    assign reduced.not_converged = nc_reg;

endmodule

`default_nettype wire

// ----- sv/l2sr_checker.sv -----
// Port-level checker for lattice_2d_shift_reduction, attached by the bind at the end.
// Depends on l2sr_pkg and on the top level's channel ports.
`default_nettype none

module l2sr_checker
    import l2sr_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic signed [OUT_W-1:0] short_x,
    input wire logic signed [OUT_W-1:0] short_y,
    input wire logic signed [OUT_W-1:0] long_x,
    input wire logic signed [OUT_W-1:0] long_y
);

    logic signed [2*OUT_W+1:0] short_norm;
    logic signed [2*OUT_W+1:0] long_norm;
    logic signed [2*OUT_W+1:0] sx_wide, sy_wide, lx_wide, ly_wide;
    logic                      in_beat;

    // Widen before squaring so the products keep every bit.
    assign sx_wide    = (2*OUT_W+2)'(short_x);
    assign sy_wide    = (2*OUT_W+2)'(short_y);
    assign lx_wide    = (2*OUT_W+2)'(long_x);
    assign ly_wide    = (2*OUT_W+2)'(long_y);
    assign short_norm = sx_wide * sx_wide + sy_wide * sy_wide;
    assign long_norm  = lx_wide * lx_wide + ly_wide * ly_wide;
    assign in_beat    = in_valid && in_ready;

    // Busy after taking a basis beat.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !in_ready)
        else $error("basis ready high right after a basis beat");

    // A result never appears the cycle right after a basis beat.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_beat))
        else $error("result beat appeared too early");

    // A stalled result holds its valid, short_x and long_x.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(short_x) && $stable(long_x))
        else $error("stalled result beat changed");

    // The short vector is never longer than the other one.
    a_short_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> short_norm <= long_norm)
        else $error("short vector longer than long vector");

endmodule

bind lattice_2d_shift_reduction l2sr_checker u_l2sr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (basis.valid),
    .in_ready  (basis.ready),
    .out_valid (reduced.valid),
    .out_ready (reduced.ready),
    .short_x   (reduced.short_x),
    .short_y   (reduced.short_y),
    .long_x    (reduced.long_x),
    .long_y    (reduced.long_y)
);

`default_nettype wire

// ----- tb/sv/lattice_2d_shift_reduction_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lattice_2d_shift_reduction: directed table plus random bases.
// Depends on l2sr_pkg, the l2sr channel interfaces and the block itself.

module lattice_2d_shift_reduction_test;
    import l2sr_pkg::*;

    // One basis beat and one reduced-result beat, at the block's own widths.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
    } basis_beat_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] short_x;
        logic signed [OUT_W-1:0] short_y;
        logic signed [OUT_W-1:0] long_x;
        logic signed [OUT_W-1:0] long_y;
        logic                    not_converged;
    } reduced_beat_t;

    // A row of the directed table: the basis, and a typed-in result where one is obvious.
    typedef struct packed {
        basis_beat_t   basis;
        logic          typed;
        reduced_beat_t want;
    } basis_row_t;

    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam reduced_beat_t NO_WANT = '0;

    localparam int N_DIRECTED = 21;
    localparam basis_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // zero basis: stops at once, both vectors zero
        '{'{0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 1'b0}},
        // zero first vector: swapped in as the short one
        '{'{0, 0, 5, 3}, 1'b1, '{0, 0, 5, 3, 1'b0}},
        // zero second vector: already short
        '{'{7, -2, 0, 0}, 1'b1, '{0, 0, 7, -2, 1'b0}},
        // orthogonal extremes, equal norms: no swap, no pass
        '{'{C_MIN, 0, 0, C_MIN}, 1'b1, '{0, C_MIN, C_MIN, 0, 1'b0}},
        '{'{C_MAX, 0, 0, C_MAX}, 1'b1, '{0, C_MAX, C_MAX, 0, 1'b0}},
        '{'{1, 0, 0, 1}, 1'b1, '{0, 1, 1, 0, 1'b0}},
        '{'{-1, 0, 0, -1}, 1'b1, '{0, -1, -1, 0, 1'b0}},
        // extreme coordinates: dependent pairs and one nearly opposite pair
        '{'{C_MIN, C_MIN, C_MAX, C_MAX}, 1'b0, NO_WANT},
        '{'{C_MAX, C_MAX, C_MIN, C_MIN}, 1'b0, NO_WANT},
        '{'{C_MIN, C_MAX, C_MAX, C_MIN}, 1'b0, NO_WANT},
        '{'{C_MAX, 0, C_MIN, 0}, 1'b0, NO_WANT},
        // small dependent pairs, negated and identical vectors
        '{'{3, 6, 1, 2}, 1'b0, NO_WANT},
        '{'{1, 2, 3, 6}, 1'b0, NO_WANT},
        '{'{2, 4, -2, -4}, 1'b0, NO_WANT},
        '{'{5, 5, 5, 5}, 1'b0, NO_WANT},
        // norm ties at the first or second swap, positive and negative inner product
        '{'{3, 4, 5, 0}, 1'b0, NO_WANT},
        '{'{3, -4, -5, 0}, 1'b0, NO_WANT},
        '{'{-1, -1, -1, 0}, 1'b0, NO_WANT},
        // nearly dependent large vectors: long chain of passes
        '{'{C_MAX, C_MAX - 1, C_MAX - 1, C_MAX - 2}, 1'b0, NO_WANT},
        '{'{C_MIN, 1, C_MAX, 0}, 1'b0, NO_WANT},
        '{'{1000003, 999999, 1, 1}, 1'b0, NO_WANT}
    };

    // Random phases: beats per phase, sender idle and receiver stall odds in percent.
    localparam int N_PHASES = 4;
    localparam int PHASE_ITEMS [N_PHASES] = '{250, 200, 200, 200};
    localparam int SEND_IDLE   [N_PHASES] = '{0, 88, 0, 31};
    localparam int RECV_STALL  [N_PHASES] = '{0, 0, 88, 31};
    localparam int N_RANDOM = 850;

    // Worst case per basis: every pass taken with the widest shift, plus idle and stall time.
    localparam longint ITEM_WORST  = 13 + MAX_PASSES * (9 + 2 * WORK_W) + 400;
    localparam longint CYCLE_LIMIT = longint'(N_DIRECTED + N_RANDOM + 16) * ITEM_WORST * 2;
    localparam int     DRAIN_CYCLES = 32;

    logic clk;
    logic rst_n;

    l2sr_basis_if   basis_ch ();
    l2sr_reduced_if reduced_ch ();

    lattice_2d_shift_reduction dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .basis   (basis_ch),
        .reduced (reduced_ch)
    );

    reduced_beat_t awaited_reductions [$];
    reduced_beat_t arrived;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     mismatches;
    int     bases_sent;
    int     reductions_checked;
    int     deepest_reduction;
    int     capped_bases;
    longint cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Bit length of an unsigned 64-bit value.
    function automatic int bit_length(logic [63:0] v);
        int n;
        n = 0;
        while (v != 0)
        begin
            n++;
            v = v >> 1;
        end
        return n;
    endfunction

    // Predict the reduced basis: power-of-two Lagrange reduction on 64-bit working values.
    // Report the number of passes taken through depth.
    function automatic reduced_beat_t reduce_basis(basis_beat_t b, output int depth);
        longint        ax, ay, bx, by, na, nb, ip, t;
        logic [63:0]   mag, psrc;
        int            s, plen, nlen;
        bit            capped;
        reduced_beat_t r;
        ax = b.first_x;
        ay = b.first_y;
        bx = b.second_x;
        by = b.second_y;
        na = ax * ax + ay * ay;
        nb = bx * bx + by * by;
        ip = ax * bx + ay * by;
        depth = 0;
        capped = 1'b0;
        forever
        begin
            // keep the shorter vector in b; ties stay in place
            if (na < nb)
            begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
                t = na; na = nb; nb = t;
            end
            mag = (ip < 0) ? -ip : ip;
            if ((mag << 1) <= $unsigned(nb))
                break;
            if (depth >= MAX_PASSES)
            begin
                capped = 1'b1;
                break;
            end
            // for a negative inner product the shift comes from |ip| - 1
            psrc = (ip < 0) ? mag - 64'd1 : mag;
            plen = bit_length(psrc);
            nlen = bit_length(nb);
            s = (plen > nlen) ? plen - nlen : 0;
            if (s > 62)
                s = 62;
            if (ip > 0)
            begin
                ax = ax - (bx <<< s);
                ay = ay - (by <<< s);
            end
            else
            begin
                ax = ax + (bx <<< s);
                ay = ay + (by <<< s);
            end
            na = ax * ax + ay * ay;
            ip = ax * bx + ay * by;
            depth++;
        end
        // on a capped run the shorter one goes first, b on a tie
        if (!capped || nb <= na)
        begin
            r.short_x = OUT_W'(bx);
            r.short_y = OUT_W'(by);
            r.long_x  = OUT_W'(ax);
            r.long_y  = OUT_W'(ay);
        end
        else
        begin
            r.short_x = OUT_W'(ax);
            r.short_y = OUT_W'(ay);
            r.long_x  = OUT_W'(bx);
            r.long_y  = OUT_W'(by);
        end
        r.not_converged = capped;
        return r;
    endfunction

    // Draw a random basis. 37 in 100 draws are shaped to force long reductions: nearly
    // dependent pairs at all scales, exact multiples and zero vectors; the other 63 are
    // full-range noise, tiny coordinates and field extremes.
    function automatic basis_beat_t random_basis();
        int          pick, m, k;
        int          c [4];
        basis_beat_t v;
        pick = int'($urandom_range(0, 99));
        if (pick < 35)
        begin
            foreach (c[i])
                c[i] = int'($urandom);
        end
        else if (pick < 55)
        begin
            foreach (c[i])
                c[i] = int'($urandom_range(0, 127)) - 64;
        end
        else if (pick < 85)
        begin
            // a = k * b + small perturbation, with |k * b| kept at most 2^22
            m = int'($urandom_range(2, 20));
            c[2] = int'($urandom_range(0, (1 << (m + 1)) - 1)) - (1 << m);
            c[3] = int'($urandom_range(0, (1 << (m + 1)) - 1)) - (1 << m);
            k = int'($urandom_range(1, 1 << (22 - m)));
            if ($urandom_range(0, 1) == 1)
                k = -k;
            c[0] = k * c[2] + int'($urandom_range(0, 6)) - 3;
            c[1] = k * c[3] + int'($urandom_range(0, 6)) - 3;
        end
        else if (pick < 92)
        begin
            // exact multiple, including a zero vector when k is zero
            c[2] = int'($urandom_range(0, 511)) - 256;
            c[3] = int'($urandom_range(0, 511)) - 256;
            k = int'($urandom_range(0, 510)) - 255;
            c[0] = k * c[2];
            c[1] = k * c[3];
        end
        else
        begin
            foreach (c[i])
            begin
                case ($urandom_range(0, 5))
                    0: c[i] = int'(C_MIN);
                    1: c[i] = int'(C_MAX);
                    2: c[i] = int'(C_MIN) + 1;
                    3: c[i] = 1;
                    4: c[i] = -1;
                    default: c[i] = 0;
                endcase
            end
        end
        // swap the vectors half the time so either one can be the long one
        if ($urandom_range(0, 1) == 1)
            v = '{COORD_WIDTH'(c[0]), COORD_WIDTH'(c[1]), COORD_WIDTH'(c[2]), COORD_WIDTH'(c[3])};
        else
            v = '{COORD_WIDTH'(c[2]), COORD_WIDTH'(c[3]), COORD_WIDTH'(c[0]), COORD_WIDTH'(c[1])};
        return v;
    endfunction

    // Offer one basis beat. Call at a falling edge; return at the falling edge after the
    // beat was taken, with valid still high so the next call can hold it or drop it.
    task automatic drive_basis(basis_beat_t b, logic typed, reduced_beat_t want);
        int depth;
        // idle cycles with junk on the payload
        while (int'($urandom_range(0, 99)) < send_idle_pct)
        begin
            basis_ch.valid    <= 1'b0;
            basis_ch.first_x  <= COORD_WIDTH'($urandom);
            basis_ch.first_y  <= COORD_WIDTH'($urandom);
            basis_ch.second_x <= COORD_WIDTH'($urandom);
            basis_ch.second_y <= COORD_WIDTH'($urandom);
            @(negedge clk);
        end
        basis_ch.valid    <= 1'b1;
        basis_ch.first_x  <= b.first_x;
        basis_ch.first_y  <= b.first_y;
        basis_ch.second_x <= b.second_x;
        basis_ch.second_y <= b.second_y;
        // hold the beat until the block takes it
        @(posedge clk);
        while (!basis_ch.ready)
            @(posedge clk);
        if (typed)
            awaited_reductions.push_back(want);
        else
        begin
            awaited_reductions.push_back(reduce_basis(b, depth));
            if (depth > deepest_reduction)
                deepest_reduction = depth;
            if (awaited_reductions[$].not_converged)
                capped_bases++;
        end
        bases_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold off until every awaited reduction has come out.
    task automatic drain_block();
        basis_ch.valid <= 1'b0;
        @(negedge clk);
        while (awaited_reductions.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(string name, logic signed [OUT_W-1:0] want,
                               logic signed [OUT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Receiver: stall at the odds of the current phase, changing only at falling edges.
    initial
    begin
        reduced_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            reduced_ch.ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
        end
    end

    // Result checker: compare every taken result beat with the oldest awaited reduction.
    always @(posedge clk)
    begin
        if (rst_n && reduced_ch.valid === 1'b1 && reduced_ch.ready === 1'b1)
        begin
            if (awaited_reductions.size() == 0)
            begin
                $error("result beat with no basis awaiting it");
                mismatches++;
            end
            else
            begin
                arrived = awaited_reductions.pop_front();
                check_field("short_x", arrived.short_x, reduced_ch.short_x);
                check_field("short_y", arrived.short_y, reduced_ch.short_y);
                check_field("long_x", arrived.long_x, reduced_ch.long_x);
                check_field("long_y", arrived.long_y, reduced_ch.long_y);
                check_field("not_converged", OUT_W'(arrived.not_converged),
                            OUT_W'(reduced_ch.not_converged));
                reductions_checked++;
            end
        end
    end

    // Watchdog: stop a hung run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d reductions awaited",
                 cycle_count, awaited_reductions.size());
        $display("simulation failed");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, drain, verdict.
    initial
    begin
        rst_n              = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        mismatches         = 0;
        bases_sent         = 0;
        reductions_checked = 0;
        deepest_reduction  = 0;
        capped_bases       = 0;
        basis_ch.valid    <= 1'b0;
        basis_ch.first_x  <= '0;
        basis_ch.first_y  <= '0;
        basis_ch.second_x <= '0;
        basis_ch.second_y <= '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, no idling on either side.
        for (int i = 0; i < N_DIRECTED; i++)
            drive_basis(DIRECTED_ROWS[i].basis, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        drain_block();

        // Random phases; between phases hold the sender until the block has emptied.
        for (int p = 0; p < N_PHASES; p++)
        begin
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            for (int n = 0; n < PHASE_ITEMS[p]; n++)
                drive_basis(random_basis(), 1'b0, NO_WANT);
            drain_block();
        end

        // Let the block settle after the last result, then judge.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bases reduced (%0d directed), %0d results compared in %0d cycles",
                 bases_sent, N_DIRECTED, reductions_checked, cycle_count);
        $display("longest predicted reduction %0d passes, %0d capped, %0d mismatches",
                 deepest_reduction, capped_bases, mismatches);
        if (mismatches == 0 && awaited_reductions.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
